[src/gco_pkg.sv]
// ----------------------------------------------------------------------------
// gco_pkg
// Shared types, constants and elaboration-time table functions for the
// great-circle odometer (CORDIC arctangents, CORDIC gain, unit conversions).
// ----------------------------------------------------------------------------
package gco_pkg;

	// default parameter values
	localparam int CORDIC_STEPS_DEF   = 28;
	localparam int TRIG_FRAC_BITS_DEF = 30;

	// field widths
	localparam int LAT_W       = 31;
	localparam int LNG_W       = 32;
	localparam int STEP_W      = 35;
	localparam int TOTAL_W     = 48;
	localparam int MIN_STEP_W  = 20;
	localparam int RADIUS_W    = 23;
	localparam int CFG_W       = 23;
	localparam int ANG_W       = 35;
	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 88;
	localparam int OUT_TUSER_W = 2;

	// register reset values
	localparam logic [MIN_STEP_W-1:0] MIN_STEP_RST = 20'd1000;
	localparam logic [RADIUS_W-1:0]   RADIUS_RST   = 23'd6366707;

	// angle constants in 1e-7 degree
	localparam logic signed [ANG_W-1:0] FULL_TURN    = 35'sd3600000000;
	localparam logic signed [ANG_W-1:0] HALF_TURN    = 35'sd1800000000;
	localparam logic signed [ANG_W-1:0] QUARTER_TURN = 35'sd900000000;

	// pi in Q4.60
	localparam logic signed [63:0] PI_Q60 = 64'sh3243F6A8885A308D;

	// 1e-7 degree to radians, scaled by 2^60
	localparam logic [30:0] DEG_TO_RAD =
		31'((64'h3243F6A8885A308D + 64'd900000000) / 64'd1800000000);

	// configuration register indexes
	typedef enum logic {
		REG_MIN_STEP = 1'b0,
		REG_RADIUS   = 1'b1
	} cfg_reg_t;

	// command to the CORDIC unit
	typedef struct packed {
		logic start;
		logic vectoring;
	} cor_cmd_t;

	// rounded Q60 to Qf
	function automatic logic signed [63:0] from_q60(input logic signed [63:0] a, input int f);
		return (a + (64'sd1 <<< (59 - f))) >>> (60 - f);
	endfunction

	// Qf product, rounded half away from zero
	function automatic logic signed [63:0] cmul_q(input logic signed [63:0] a,
		input logic signed [63:0] b, input int f);
		logic [63:0]  ma;
		logic [63:0]  mb;
		logic [127:0] p;
		logic [63:0]  m;
		ma = (a < 0) ? 64'(-a) : 64'(a);
		mb = (b < 0) ? 64'(-b) : 64'(b);
		p  = {64'd0, ma} * {64'd0, mb};
		p  = p + (128'd1 << (f - 1));
		m  = 64'(p >> f);
		return ((a < 0) != (b < 0)) ? -$signed(m) : $signed(m);
	endfunction

	// arctan(2^-i) in Qf
	function automatic logic signed [63:0] atan_q(input int i, input int f);
		logic signed [63:0] acc;
		logic signed [63:0] term;
		int sh;
		int k;
		acc = 64'sd0;
		sh  = i;
		if (i == 0)
			return from_q60(PI_Q60 >>> 2, f);
		for (k = 0; k < 32; k++) begin
			if (sh <= 60) begin
				term = $signed((64'd1 << (60 - sh)) / 64'(2 * k + 1));
				acc  = k[0] ? acc - term : acc + term;
				sh   = sh + 2 * i;
			end
		end
		return from_q60(acc, f);
	endfunction

	// reciprocal of the CORDIC gain in Qf, by Newton iteration
	function automatic logic signed [63:0] gain_inv(input int steps, input int f);
		logic signed [63:0] p;
		logic signed [63:0] k;
		int i;
		p = 64'sd1 <<< f;
		for (i = 0; i < steps; i++)
			if (2 * i < 63)
				p = p + (p >>> (2 * i));
		k = (64'sd3 <<< f) / 5;
		for (i = 0; i < 8; i++)
			k = cmul_q(k, (64'sd3 <<< f) - cmul_q(p, cmul_q(k, k, f), f), f) / 2;
		return k;
	endfunction

	// pi/2 in Qf
	function automatic logic signed [63:0] half_pi(input int f);
		return from_q60(PI_Q60 >>> 1, f);
	endfunction

endpackage

[src/gco_mul.sv]
// ----------------------------------------------------------------------------
// gco_mul
// Bit-serial unsigned shift-add multiplier, one partial product per cycle.
// ----------------------------------------------------------------------------
module gco_mul #(
	parameter int OPW = 33
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [OPW-1:0]   a,
	input  logic [OPW-1:0]   b,
	output logic [2*OPW-1:0] p,
	output logic             done
);

	localparam int CW = $clog2(OPW + 1);

	logic [OPW-1:0]   b_q;
	logic [2*OPW-1:0] p_q;
	logic [CW-1:0]    cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [OPW:0]     sum;

	// add multiplicand when the low multiplier bit is set
	assign sum  = {1'b0, p_q[2*OPW-1:OPW]} + (p_q[0] ? {1'b0, b_q} : '0);
	assign p    = p_q;
	assign done = done_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(OPW - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			b_q <= b;
			p_q <= {OPW'(0), a};
		end else if (busy_q) begin
			p_q <= {sum, p_q[OPW-1:1]};
		end
	end

endmodule

[src/gco_sqrt.sv]
// ----------------------------------------------------------------------------
// gco_sqrt
// Restoring digit-by-digit square root: floor(sqrt(s * 2^F)), one result bit
// per cycle.
// ----------------------------------------------------------------------------
module gco_sqrt #(
	parameter int F = 30
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [F:0] s,
	output logic [F:0] root,
	output logic       done
);

	localparam int RW = F + 4;
	localparam int NW = 2 * F + 2;
	localparam int CW = $clog2(F + 2);

	logic [NW-1:0] n_q;
	logic [RW-1:0] rem_q;
	logic [F:0]    root_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [RW-1:0] rem2;
	logic [RW-1:0] trial;
	logic          ge;

	// one trial subtraction
	assign rem2  = {rem_q[RW-3:0], n_q[NW-1:NW-2]};
	assign trial = RW'({root_q, 2'b01});
	assign ge    = rem2 >= trial;
	assign root  = root_q;
	assign done  = done_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(F)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			n_q    <= NW'({s, F'(0)});
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			n_q    <= n_q << 2;
			rem_q  <= ge ? rem2 - trial : rem2;
			root_q <= {root_q[F-1:0], ge};
		end
	end

endmodule

[src/gco_cordic.sv]
// ----------------------------------------------------------------------------
// gco_cordic
// Shared CORDIC micro-rotation unit, rotation or vectoring mode, one
// iteration per cycle.
// ----------------------------------------------------------------------------
module gco_cordic #(
	parameter int W     = 34,
	parameter int STEPS = 28,
	parameter int F     = 30
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  gco_pkg::cor_cmd_t       cmd,
	input  logic signed [W-1:0]     x0,
	input  logic signed [W-1:0]     y0,
	input  logic signed [W-1:0]     z0,
	output logic signed [W-1:0]     x,
	output logic signed [W-1:0]     y,
	output logic signed [W-1:0]     z,
	output logic                    done
);

	import gco_pkg::*;

	localparam int IW = $clog2(STEPS);

	logic signed [W-1:0] atan_w [STEPS];
	logic signed [W-1:0] x_q;
	logic signed [W-1:0] y_q;
	logic signed [W-1:0] z_q;
	logic [IW-1:0]       idx_q;
	logic                vec_q;
	logic                busy_q;
	logic                done_q;
	logic signed [W-1:0] xs;
	logic signed [W-1:0] ys;
	logic signed [W-1:0] a;
	logic                dir;
	logic                hold;

	// arctangent table
	for (genvar g = 0; g < STEPS; g++) begin : g_atan
		assign atan_w[g] = W'(atan_q(g, F));
	end

	// rotation direction
	assign xs   = x_q >>> idx_q;
	assign ys   = y_q >>> idx_q;
	assign a    = atan_w[idx_q];
	assign dir  = vec_q ? (y_q < 0) : (z_q >= 0);
	assign hold = vec_q && (y_q == '0);

	assign x    = x_q;
	assign y    = y_q;
	assign z    = z_q;
	assign done = done_q;

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			idx_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
			end else if (busy_q) begin
				idx_q <= idx_q + 1'b1;
				if (idx_q == IW'(STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// micro-rotation
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			x_q   <= x0;
			y_q   <= y0;
			z_q   <= z0;
			vec_q <= cmd.vectoring;
		end else if (busy_q && !hold) begin
			if (dir) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - a;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + a;
			end
		end
	end

endmodule

[src/great_circle_odometer.sv]
// ----------------------------------------------------------------------------
// great_circle_odometer
// Handles one fix at a time: a new input is accepted only in the idle state,
// after the previous result has been registered. Throughput is set by the
// bit-serial multiplier (used 8 times), the CORDIC unit (used 4 times) and the
// square root; a result held at the output stalls the next fix.
// Reset clears the reference, the total and the registers to their defaults.
// ----------------------------------------------------------------------------
module great_circle_odometer #(
	parameter int CORDIC_STEPS   = gco_pkg::CORDIC_STEPS_DEF,
	parameter int TRIG_FRAC_BITS = gco_pkg::TRIG_FRAC_BITS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// latitude, longitude
	input  logic [gco_pkg::IN_TDATA_W-1:0]   s_tdata,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// step_mm, total_mm
	output logic [gco_pkg::OUT_TDATA_W-1:0]  m_tdata,
	// reference_only, total_saturated
	output logic [gco_pkg::OUT_TUSER_W-1:0]  m_tuser,
	input  logic                             cfg_we,
	input  gco_pkg::cfg_reg_t                cfg_index,
	input  logic [gco_pkg::CFG_W-1:0]        cfg_data
);

	import gco_pkg::*;

	localparam int F   = TRIG_FRAC_BITS;
	localparam int W   = F + 4;
	localparam int OPW = (F + 3 > 33) ? F + 3 : 33;
	localparam int PW  = 2 * OPW;

	localparam logic signed [W-1:0] ONE_Q     = W'(64'd1 << F);
	localparam logic signed [W-1:0] NEG_ONE_Q = -ONE_Q;
	localparam logic signed [W-1:0] GAIN_INV  = W'(gain_inv(CORDIC_STEPS, F));
	localparam logic signed [W-1:0] HALF_PI   = W'(half_pi(F));
	localparam logic [PW:0]         RND_F     = (PW + 1)'(1) << (F - 1);
	localparam logic [PW:0]         RND_Z     = (PW + 1)'(1) << (59 - F);
	localparam logic [TOTAL_W-1:0]  TOTAL_MAX = '1;

	typedef enum logic [3:0] {
		S_IDLE, S_RED, S_WRAP, S_FOLD, S_ZMUL, S_ROT, S_M1, S_M2, S_M3,
		S_CLAMP, S_TT, S_SQ, S_VEC, S_DIST, S_FIN
	} state_t;

	state_t state_q;

	// configuration and persistent state
	logic [MIN_STEP_W-1:0]    min_step_q;
	logic [RADIUS_W-1:0]      radius_q;
	logic signed [LAT_W-1:0]  prev_lat_q;
	logic signed [LNG_W-1:0]  prev_lng_q;
	logic [TOTAL_W-1:0]       total_q;
	logic                     have_ref_q;

	// working registers
	logic signed [LAT_W-1:0]  lat_q;
	logic signed [LNG_W-1:0]  lng_q;
	logic signed [ANG_W-1:0]  ang_q;
	logic [1:0]               ang_idx_q;
	logic                     flip_q;
	logic                     zneg_q;
	logic                     mul_neg_q;
	logic signed [W-1:0]      s1_q;
	logic signed [W-1:0]      c1_q;
	logic signed [W-1:0]      s2_q;
	logic signed [W-1:0]      c2_q;
	logic signed [W-1:0]      c3_q;
	logic signed [W-1:0]      s12_q;
	logic signed [W-1:0]      t_q;
	logic [STEP_W-1:0]        step_q;
	logic                     ref_q;

	// output register
	logic                     out_valid_q;
	logic [STEP_W-1:0]        out_step_q;
	logic [TOTAL_W-1:0]       out_total_q;
	logic                     out_ref_q;
	logic                     out_sat_q;

	// unit interfaces
	logic                     mul_start_q;
	logic [OPW-1:0]           mul_a_q;
	logic [OPW-1:0]           mul_b_q;
	logic [PW-1:0]            mul_p;
	logic                     mul_done;
	cor_cmd_t                 cor_cmd_q;
	logic signed [W-1:0]      cor_x0_q;
	logic signed [W-1:0]      cor_y0_q;
	logic signed [W-1:0]      cor_z0_q;
	logic signed [W-1:0]      cor_x;
	logic signed [W-1:0]      cor_y;
	logic signed [W-1:0]      cor_z;
	logic                     cor_done;
	logic                     sq_start_q;
	logic [F:0]               sq_s_q;
	logic [F:0]               sq_root;
	logic                     sq_done;

	// combinational helpers
	logic signed [LAT_W-1:0]  in_lat;
	logic signed [LNG_W-1:0]  in_lng;
	logic signed [ANG_W-1:0]  red_m;
	logic signed [ANG_W-1:0]  wrap_m;
	logic signed [ANG_W-1:0]  fold_m;
	logic                     fold_flip;
	logic signed [ANG_W-1:0]  fold_mag;
	logic signed [W-1:0]      mq_abs;
	logic signed [W-1:0]      mq;
	logic signed [W-1:0]      z_abs;
	logic signed [W-1:0]      rot_cos;
	logic signed [W-1:0]      t_sum;
	logic signed [W-1:0]      t_clamp;
	logic signed [W-1:0]      s_rem;
	logic signed [W-1:0]      s_clip;
	logic signed [W-1:0]      root_w;
	logic [STEP_W-1:0]        step_full;
	logic [32:0]              r1000;
	logic [TOTAL_W:0]         total_sum;
	logic [TOTAL_W-1:0]       new_total;

	function automatic logic [OPW-1:0] mag_op(input logic signed [W-1:0] v);
		logic signed [W-1:0] m;
		m = (v < 0) ? -v : v;
		return OPW'($unsigned(m));
	endfunction

	// shared units
	gco_mul #(
		.OPW(OPW)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.start (mul_start_q),
		.a     (mul_a_q),
		.b     (mul_b_q),
		.p     (mul_p),
		.done  (mul_done)
	);

	gco_cordic #(
		.W    (W),
		.STEPS(CORDIC_STEPS),
		.F    (F)
	) u_cordic (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (cor_cmd_q),
		.x0    (cor_x0_q),
		.y0    (cor_y0_q),
		.z0    (cor_z0_q),
		.x     (cor_x),
		.y     (cor_y),
		.z     (cor_z),
		.done  (cor_done)
	);

	gco_sqrt #(
		.F(F)
	) u_sqrt (
		.clk   (clk),
		.arst_n(arst_n),
		.start (sq_start_q),
		.s     (sq_s_q),
		.root  (sq_root),
		.done  (sq_done)
	);

	// ports
	assign s_tready = (state_q == S_IDLE);
	assign in_lat   = $signed(s_tdata[LAT_W-1:0]);
	assign in_lng   = $signed(s_tdata[LAT_W+LNG_W-1:LAT_W]);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_TDATA_W'({out_total_q, out_step_q});
	assign m_tuser  = {out_sat_q, out_ref_q};

	// angle reduction: remainder, wrap to half turn, fold to quarter turn
	always_comb begin
		if (ang_q >= FULL_TURN)
			red_m = ang_q - FULL_TURN;
		else if (ang_q <= -FULL_TURN)
			red_m = ang_q + FULL_TURN;
		else
			red_m = ang_q;

		if (ang_q > HALF_TURN)
			wrap_m = ang_q - FULL_TURN;
		else if (ang_q <= -HALF_TURN)
			wrap_m = ang_q + FULL_TURN;
		else
			wrap_m = ang_q;

		fold_flip = 1'b1;
		if (ang_q > QUARTER_TURN)
			fold_m = HALF_TURN - ang_q;
		else if (ang_q < -QUARTER_TURN)
			fold_m = -HALF_TURN - ang_q;
		else begin
			fold_m    = ang_q;
			fold_flip = 1'b0;
		end
		fold_mag = (fold_m < 0) ? -fold_m : fold_m;
	end

	// rounding of multiplier results
	assign mq_abs    = W'(({1'b0, mul_p} + RND_F) >> F);
	assign mq        = mul_neg_q ? -mq_abs : mq_abs;
	assign z_abs     = W'(({1'b0, mul_p} + RND_Z) >> (60 - F));
	assign step_full = STEP_W'(({1'b0, mul_p} + RND_F) >> F);

	// cosine sign, acos argument and sqrt radicand
	assign rot_cos = flip_q ? -cor_x : cor_x;
	assign t_sum   = s12_q + mq;
	assign t_clamp = (t_sum > ONE_Q) ? ONE_Q : ((t_sum < NEG_ONE_Q) ? NEG_ONE_Q : t_sum);
	assign s_rem   = ONE_Q - mq;
	assign s_clip  = (s_rem < 0) ? '0 : s_rem;
	assign root_w  = W'(sq_root);

	// radius in millimetres: r * 1024 - r * 16 - r * 8
	assign r1000 = (33'(radius_q) << 10) - (33'(radius_q) << 4) - (33'(radius_q) << 3);

	// saturating total
	assign total_sum = {1'b0, total_q} + (TOTAL_W + 1)'(step_q);
	assign new_total = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			min_step_q  <= MIN_STEP_RST;
			radius_q    <= RADIUS_RST;
			prev_lat_q  <= '0;
			prev_lng_q  <= '0;
			total_q     <= '0;
			have_ref_q  <= 1'b0;
			lat_q       <= '0;
			lng_q       <= '0;
			ang_q       <= '0;
			ang_idx_q   <= '0;
			flip_q      <= 1'b0;
			zneg_q      <= 1'b0;
			mul_neg_q   <= 1'b0;
			s1_q        <= '0;
			c1_q        <= '0;
			s2_q        <= '0;
			c2_q        <= '0;
			c3_q        <= '0;
			s12_q       <= '0;
			t_q         <= '0;
			step_q      <= '0;
			ref_q       <= 1'b0;
			out_valid_q <= 1'b0;
			out_step_q  <= '0;
			out_total_q <= '0;
			out_ref_q   <= 1'b0;
			out_sat_q   <= 1'b0;
			mul_start_q <= 1'b0;
			mul_a_q     <= '0;
			mul_b_q     <= '0;
			cor_cmd_q   <= '0;
			cor_x0_q    <= '0;
			cor_y0_q    <= '0;
			cor_z0_q    <= '0;
			sq_start_q  <= 1'b0;
			sq_s_q      <= '0;
		end else begin
			mul_start_q     <= 1'b0;
			cor_cmd_q.start <= 1'b0;
			sq_start_q      <= 1'b0;

			// output transaction taken
			if (m_tvalid && m_tready)
				out_valid_q <= 1'b0;

			// register writes
			if (cfg_we) begin
				unique case (cfg_index)
					REG_MIN_STEP: min_step_q <= cfg_data[MIN_STEP_W-1:0];
					REG_RADIUS:   radius_q   <= cfg_data[RADIUS_W-1:0];
					default:      ;
				endcase
			end

			unique case (state_q)
				S_IDLE: begin
					if (s_tvalid) begin
						lat_q <= in_lat;
						lng_q <= in_lng;
						if (!have_ref_q) begin
							step_q  <= '0;
							ref_q   <= 1'b1;
							state_q <= S_FIN;
						end else begin
							ref_q     <= 1'b0;
							ang_idx_q <= 2'd0;
							ang_q     <= ANG_W'(prev_lat_q);
							state_q   <= S_RED;
						end
					end
				end
				S_RED: begin
					ang_q   <= red_m;
					state_q <= S_WRAP;
				end
				S_WRAP: begin
					ang_q   <= wrap_m;
					state_q <= S_FOLD;
				end
				S_FOLD: begin
					flip_q      <= fold_flip;
					zneg_q      <= fold_m < 0;
					mul_a_q     <= OPW'($unsigned(fold_mag));
					mul_b_q     <= OPW'(DEG_TO_RAD);
					mul_start_q <= 1'b1;
					state_q     <= S_ZMUL;
				end
				S_ZMUL: begin
					if (mul_done) begin
						cor_x0_q  <= GAIN_INV;
						cor_y0_q  <= '0;
						cor_z0_q  <= zneg_q ? -z_abs : z_abs;
						cor_cmd_q <= '{start: 1'b1, vectoring: 1'b0};
						state_q   <= S_ROT;
					end
				end
				S_ROT: begin
					if (cor_done) begin
						case (ang_idx_q)
							2'd0: begin
								s1_q      <= cor_y;
								c1_q      <= rot_cos;
								ang_q     <= ANG_W'(lat_q);
								ang_idx_q <= 2'd1;
								state_q   <= S_RED;
							end
							2'd1: begin
								s2_q      <= cor_y;
								c2_q      <= rot_cos;
								ang_q     <= ANG_W'(prev_lng_q) - ANG_W'(lng_q);
								ang_idx_q <= 2'd2;
								state_q   <= S_RED;
							end
							default: begin
								c3_q        <= rot_cos;
								mul_a_q     <= mag_op(s1_q);
								mul_b_q     <= mag_op(s2_q);
								mul_neg_q   <= s1_q[W-1] ^ s2_q[W-1];
								mul_start_q <= 1'b1;
								state_q     <= S_M1;
							end
						endcase
					end
				end
				S_M1: begin
					if (mul_done) begin
						s12_q       <= mq;
						mul_a_q     <= mag_op(c1_q);
						mul_b_q     <= mag_op(c2_q);
						mul_neg_q   <= c1_q[W-1] ^ c2_q[W-1];
						mul_start_q <= 1'b1;
						state_q     <= S_M2;
					end
				end
				S_M2: begin
					if (mul_done) begin
						mul_a_q     <= mag_op(mq);
						mul_b_q     <= mag_op(c3_q);
						mul_neg_q   <= mq[W-1] ^ c3_q[W-1];
						mul_start_q <= 1'b1;
						state_q     <= S_M3;
					end
				end
				S_M3: begin
					if (mul_done) begin
						t_q     <= t_clamp;
						state_q <= S_CLAMP;
					end
				end
				S_CLAMP: begin
					mul_a_q     <= mag_op(t_q);
					mul_b_q     <= mag_op(t_q);
					mul_neg_q   <= 1'b0;
					mul_start_q <= 1'b1;
					state_q     <= S_TT;
				end
				S_TT: begin
					if (mul_done) begin
						sq_s_q     <= s_clip[F:0];
						sq_start_q <= 1'b1;
						state_q    <= S_SQ;
					end
				end
				S_SQ: begin
					if (sq_done) begin
						// negative argument: start a quarter turn on
						if (t_q < 0) begin
							cor_x0_q <= root_w;
							cor_y0_q <= -t_q;
							cor_z0_q <= HALF_PI;
						end else begin
							cor_x0_q <= t_q;
							cor_y0_q <= root_w;
							cor_z0_q <= '0;
						end
						cor_cmd_q <= '{start: 1'b1, vectoring: 1'b1};
						state_q   <= S_VEC;
					end
				end
				S_VEC: begin
					if (cor_done) begin
						mul_a_q     <= (cor_z < 0) ? '0 : mag_op(cor_z);
						mul_b_q     <= OPW'(r1000);
						mul_neg_q   <= 1'b0;
						mul_start_q <= 1'b1;
						state_q     <= S_DIST;
					end
				end
				S_DIST: begin
					if (mul_done) begin
						step_q  <= (step_full <= STEP_W'(min_step_q)) ? '0 : step_full;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_step_q  <= step_q;
						out_total_q <= new_total;
						out_ref_q   <= ref_q;
						out_sat_q   <= (new_total == TOTAL_MAX);
						total_q     <= new_total;
						prev_lat_q  <= lat_q;
						prev_lng_q  <= lng_q;
						have_ref_q  <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

[verif/great_circle_odometer_tb.sv]
// ----------------------------------------------------------------------------
// great_circle_odometer_tb
// Streams position fixes into the odometer under several threshold and radius
// settings and checks every distance result against a bit-accurate predictor
// of the CORDIC law-of-cosines datapath, with random idling on both streams.
// ----------------------------------------------------------------------------
module great_circle_odometer_tb;
	import gco_pkg::*;

	localparam int    NSTEPS = CORDIC_STEPS_DEF;
	localparam int    FRAC   = TRIG_FRAC_BITS_DEF;
	localparam longint ONE_Q = longint'(1) << FRAC;
	localparam longint TURN  = 64'sd3600000000;
	localparam longint HALF  = 64'sd1800000000;
	localparam longint QUART = 64'sd900000000;
	localparam longint PI60  = 64'sh3243F6A8885A308D;
	localparam bit [63:0] TOTAL_TOP = 64'hFFFF_FFFF_FFFF;
	localparam int    RANDOM_PER_PHASE = 320;
	localparam int    NPHASES = 6;

	typedef struct {
		logic signed [LAT_W-1:0] lat;
		logic signed [LNG_W-1:0] lng;
	} fix_t;

	typedef struct {
		logic [STEP_W-1:0]  step_mm;
		logic [TOTAL_W-1:0] total_mm;
		logic               ref_only;
		logic               saturated;
	} odo_out_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	// latitude, longitude
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready;
	// step_mm, total_mm
	logic [OUT_TDATA_W-1:0] m_tdata;
	// reference_only, total_saturated
	logic [OUT_TUSER_W-1:0] m_tuser;
	logic                   cfg_we;
	cfg_reg_t               cfg_index;
	logic [CFG_W-1:0]       cfg_data;

	great_circle_odometer u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// predictor state and configuration
	longint    atan_tab [NSTEPS];
	longint    cordic_k;
	bit [63:0] thr_mm;
	bit [63:0] radius_m;
	longint    last_lat;
	longint    last_lng;
	bit [63:0] odo_total;
	bit        has_ref;

	fix_t     fix_queue [$];
	odo_out_t expected_q [$];
	fix_t     cur_fix;
	int       n_errors;
	int       n_fixes;
	int       n_results;
	int       n_nonzero;
	int       send_gap;
	int       recv_gap;
	int       hold_left;
	bit       hold_done;
	bit       no_idle;

	// generator position
	longint   gen_lat;
	longint   gen_lng;

	// clock
	initial clk = 1'b0;
	always #4 clk = ~clk;

	// rounded Q product, half away from zero
	function automatic longint q_mul(longint a, longint b);
		bit [63:0]  ma;
		bit [63:0]  mb;
		bit [127:0] p;
		bit [63:0]  m;
		ma = (a < 0) ? 64'(-a) : 64'(a);
		mb = (b < 0) ? 64'(-b) : 64'(b);
		p  = {64'd0, ma} * {64'd0, mb};
		p  = p + (128'd1 << (FRAC - 1));
		m  = 64'(p >> FRAC);
		return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
	endfunction

	function automatic longint q60_round(longint a);
		return (a + (longint'(1) << (59 - FRAC))) >>> (60 - FRAC);
	endfunction

	// arctangent table and reciprocal gain
	task automatic build_tables();
		longint    acc;
		bit [63:0] term;
		longint    p;
		longint    k;
		int        sh;
		int        j;
		atan_tab[0] = q60_round(PI60 >>> 2);
		for (int i = 1; i < NSTEPS; i++) begin
			acc = 0;
			sh  = i;
			j   = 0;
			while (sh <= 60) begin
				term = (64'd1 << (60 - sh)) / 64'(2 * j + 1);
				acc  = j[0] ? acc - longint'(term) : acc + longint'(term);
				j++;
				sh += 2 * i;
			end
			atan_tab[i] = q60_round(acc);
		end
		p = ONE_Q;
		for (int i = 0; i < NSTEPS; i++)
			if (2 * i < 63)
				p = p + (p >>> (2 * i));
		k = (ONE_Q * 3) / 5;
		for (int i = 0; i < 8; i++)
			k = q_mul(k, 3 * ONE_Q - q_mul(p, q_mul(k, k))) / 2;
		cordic_k = k;
	endtask

	// sine and cosine of an angle in 1e-7 degree
	task automatic trig_of(input longint v, output longint s, output longint c);
		longint    m;
		longint    x;
		longint    y;
		longint    z;
		longint    nx;
		bit        flip;
		bit [63:0] conv;
		bit [63:0] um;
		m    = v % TURN;
		flip = 1'b0;
		conv = (64'(PI60) + 64'(QUART)) / 64'(HALF);
		if (m > HALF) m -= TURN;
		if (m <= -HALF) m += TURN;
		if (m > QUART) begin
			m = HALF - m;
			flip = 1'b1;
		end else if (m < -QUART) begin
			m = -HALF - m;
			flip = 1'b1;
		end
		um = (m < 0) ? 64'(-m) : 64'(m);
		z  = longint'((um * conv + (64'd1 << (59 - FRAC))) >> (60 - FRAC));
		if (m < 0) z = -z;
		x = cordic_k;
		y = 0;
		for (int i = 0; i < NSTEPS; i++) begin
			if (z >= 0) begin
				nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i];
			end else begin
				nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i];
			end
			x = nx;
		end
		s = y;
		c = flip ? -x : x;
	endtask

	// central angle from its cosine
	function automatic longint arc_of(longint t);
		longint     s;
		longint     x;
		longint     y;
		longint     z;
		longint     nx;
		bit [127:0] target;
		bit [63:0]  r;
		bit [63:0]  cand;
		z = 0;
		if (t > ONE_Q) t = ONE_Q;
		if (t < -ONE_Q) t = -ONE_Q;
		s = ONE_Q - q_mul(t, t);
		if (s < 0) s = 0;
		target = 128'(s) << FRAC;
		r = 0;
		for (int b = FRAC; b >= 0; b--) begin
			cand = r | (64'd1 << b);
			if ({64'd0, cand} * {64'd0, cand} <= target)
				r = cand;
		end
		y = longint'(r);
		x = t;
		if (x < 0) begin
			nx = y; y = -x; x = nx;
			z = q60_round(PI60 >>> 1);
		end
		for (int i = 0; i < NSTEPS; i++) begin
			if (y > 0) begin
				nx = x + (y >>> i); y = y - (x >>> i); z += atan_tab[i]; x = nx;
			end else if (y < 0) begin
				nx = x - (y >>> i); y = y + (x >>> i); z -= atan_tab[i]; x = nx;
			end
		end
		return (z < 0) ? 0 : z;
	endfunction

	// odometer update for one accepted fix
	task automatic odometer_step(input fix_t f, output odo_out_t o);
		longint     lat;
		longint     lng;
		longint     s1, c1, s2, c2, s3, c3;
		longint     t;
		longint     th;
		bit [127:0] w;
		bit [63:0]  step;
		lat  = longint'(f.lat);
		lng  = longint'(f.lng);
		step = 0;
		o.ref_only = 1'b0;
		if (!has_ref) begin
			has_ref = 1'b1;
			o.ref_only = 1'b1;
		end else begin
			trig_of(last_lat, s1, c1);
			trig_of(lat, s2, c2);
			trig_of(last_lng - lng, s3, c3);
			t  = q_mul(s1, s2) + q_mul(q_mul(c1, c2), c3);
			th = arc_of(t);
			w  = {64'd0, 64'(th)} * {64'd0, radius_m * 64'd1000};
			w  = w + (128'd1 << (FRAC - 1));
			step = 64'(w >> FRAC) & 64'h7_FFFF_FFFF;
			if (step <= thr_mm) step = 0;
			odo_total = odo_total + step;
			if (odo_total > TOTAL_TOP) odo_total = TOTAL_TOP;
		end
		last_lat    = lat;
		last_lng    = lng;
		o.step_mm   = step[STEP_W-1:0];
		o.total_mm  = odo_total[TOTAL_W-1:0];
		o.saturated = (odo_total == TOTAL_TOP);
	endtask

	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 60) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(20, 200);
	endfunction

	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (n_errors < 40)
			$display("mismatch on result %0d: %s got %0d expected %0d",
				n_results, what, got, want);
		n_errors++;
	endtask

	// driver: offers pending fixes, predicts on every accepted transaction
	always @(posedge clk or negedge arst_n) begin
		odo_out_t exp_o;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			send_gap <= 0;
		end else begin
			if (s_tvalid && s_tready) begin
				odometer_step(cur_fix, exp_o);
				expected_q.push_back(exp_o);
				n_fixes++;
			end
			if (!(s_tvalid && !s_tready)) begin
				if (send_gap > 0) begin
					s_tvalid <= 1'b0;
					send_gap <= send_gap - 1;
				end else if (fix_queue.size() > 0) begin
					cur_fix = fix_queue.pop_front();
					s_tdata  <= {1'b0, cur_fix.lng, cur_fix.lat};
					s_tvalid <= 1'b1;
					send_gap <= idle_len();
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// monitor: random back-pressure, one long hold, field-by-field check
	always @(posedge clk or negedge arst_n) begin
		odo_out_t want;
		if (!arst_n) begin
			m_tready  <= 1'b0;
			recv_gap  <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_q.size() == 0) begin
					report_mismatch("unexpected result", m_tdata[63:0], 0);
				end else begin
					want = expected_q.pop_front();
					if (m_tdata[STEP_W-1:0] !== want.step_mm)
						report_mismatch("step_mm", m_tdata[STEP_W-1:0], want.step_mm);
					if (m_tdata[STEP_W+TOTAL_W-1:STEP_W] !== want.total_mm)
						report_mismatch("total_mm", m_tdata[STEP_W+TOTAL_W-1:STEP_W],
							want.total_mm);
					if (m_tuser[0] !== want.ref_only)
						report_mismatch("reference_only", m_tuser[0], want.ref_only);
					if (m_tuser[1] !== want.saturated)
						report_mismatch("total_saturated", m_tuser[1], want.saturated);
					if (want.step_mm != 0) n_nonzero++;
				end
				n_results++;
			end
			if (!hold_done && n_results == 40) begin
				hold_done <= 1'b1;
				hold_left <= 3000;
				m_tready  <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left <= hold_left - 1;
				m_tready  <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				recv_gap <= idle_len();
			end
		end
	end

	task automatic add_fix(input longint lat, input longint lng);
		fix_t f;
		f.lat = lat[LAT_W-1:0];
		f.lng = lng[LNG_W-1:0];
		fix_queue.push_back(f);
		gen_lat = longint'(f.lat);
		gen_lng = longint'(f.lng);
	endtask

	// random fix, mostly a short hop from the last one
	task automatic add_random_fix();
		int mode;
		mode = $urandom_range(0, 9);
		case (mode)
			0, 1, 2, 3: begin
				add_fix(gen_lat + $signed($urandom_range(0, 4000)) - 2000,
					gen_lng + $signed($urandom_range(0, 4000)) - 2000);
			end
			4: begin
				add_fix(gen_lat + $signed($urandom_range(0, 4000000)) - 2000000,
					gen_lng + $signed($urandom_range(0, 4000000)) - 2000000);
			end
			5: add_fix(gen_lat, gen_lng);
			6: begin
				add_fix(longint'($urandom_range(0, 1800000000)) - QUART,
					longint'($urandom_range(0, 2 * 1800000000)) - HALF);
			end
			7: add_fix(longint'($signed($urandom())), longint'($signed($urandom())));
			8: add_fix(-gen_lat, gen_lng + HALF);
			default: begin
				add_fix(gen_lat + $signed($urandom_range(0, 200)) - 100,
					gen_lng + $signed($urandom_range(0, 200)) - 100);
			end
		endcase
	endtask

	task automatic program_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		if (idx == REG_MIN_STEP) thr_mm = 64'(val[MIN_STEP_W-1:0]);
		else radius_m = 64'(val[RADIUS_W-1:0]);
	endtask

	task automatic wait_drained();
		while (fix_queue.size() > 0 || s_tvalid || expected_q.size() > 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
	endtask

	// stimulus
	initial begin
		logic [CFG_W-1:0] thr_set [NPHASES];
		logic [CFG_W-1:0] rad_set [NPHASES];
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = REG_MIN_STEP;
		cfg_data  = '0;
		n_errors  = 0;
		n_fixes   = 0;
		n_results = 0;
		n_nonzero = 0;
		no_idle   = 1'b0;
		gen_lat   = 0;
		gen_lng   = 0;
		thr_mm    = 64'(MIN_STEP_RST);
		radius_m  = 64'(RADIUS_RST);
		last_lat  = 0;
		last_lng  = 0;
		odo_total = 0;
		has_ref   = 1'b0;
		build_tables();
		thr_set = '{23'd1000, 23'd0, 23'd1000000, 23'($urandom_range(0, 1000000)),
			23'd0, 23'($urandom_range(0, 5000))};
		rad_set = '{23'd6366707, 23'd6000000, 23'd6500000, 23'd0, 23'h7FFFFF,
			23'($urandom_range(6000000, 6500000))};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		for (int ph = 0; ph < NPHASES; ph++) begin
			program_reg(REG_MIN_STEP, thr_set[ph]);
			program_reg(REG_RADIUS, rad_set[ph]);
			@(posedge clk);
			cfg_we <= 1'b0;
			no_idle = (ph == 2);
			if (ph == 0) begin
				// first fix only sets the reference
				add_fix(0, 0);
				add_fix(0, 0);
				add_fix(5, 5);
				add_fix(900, 0);
				add_fix(900000000, 0);
				add_fix(-900000000, 0);
				add_fix(0, 1800000000);
				add_fix(0, -1800000000);
				add_fix(-(longint'(1) << 30), -(longint'(1) << 31));
				add_fix((longint'(1) << 30) - 1, (longint'(1) << 31) - 1);
				add_fix(450000000, 1799999999);
				add_fix(-450000000, -1799999999);
				add_fix(0, 0);
				add_fix(0, 1800000000);
				add_fix(899999999, 123456789);
				add_fix(-899999999, -1676543211);
				add_fix(1000000000, 0);
				add_fix(-1000000000, 0);
				add_fix(1, -1);
				add_fix(1, -1);
				add_fix(-1, 1);
			end
			for (int n = 0; n < RANDOM_PER_PHASE; n++)
				add_random_fix();
			wait_drained();
		end
		$display("covered %0d fixes over %0d register settings, %0d results, %0d non-zero steps",
			n_fixes, NPHASES, n_results, n_nonzero);
		if (n_errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// watchdog
	initial begin
		#80000000;
		$display("timeout with %0d results outstanding", expected_q.size());
		$display("status: fail");
		$finish;
	end

endmodule

[sim.f]
src/gco_pkg.sv
src/gco_mul.sv
src/gco_sqrt.sv
src/gco_cordic.sv
src/great_circle_odometer.sv
verif/great_circle_odometer_tb.sv
